[rtl/stl_pkg.sv]
// Shared types, constants and character helpers for the source text lexer.
`default_nettype none

package stl_pkg;

    localparam int LINE_W = 20;
    localparam int OFF_W  = 24;
    localparam int LEN_W  = 7;

    localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

    localparam logic [4:0] KIND_NONE  = 5'd0;
    localparam logic [4:0] KIND_IDENT = 5'd6;
    localparam logic [4:0] KIND_INT   = 5'd7;
    localparam logic [4:0] KIND_LPAR  = 5'd8;
    localparam logic [4:0] KIND_RPAR  = 5'd9;
    localparam logic [4:0] KIND_LBRC  = 5'd10;
    localparam logic [4:0] KIND_RBRC  = 5'd11;
    localparam logic [4:0] KIND_EQ    = 5'd12;
    localparam logic [4:0] KIND_PLUS  = 5'd13;
    localparam logic [4:0] KIND_MINUS = 5'd14;
    localparam logic [4:0] KIND_STAR  = 5'd15;
    localparam logic [4:0] KIND_SLASH = 5'd16;
    localparam logic [4:0] KIND_SEMI  = 5'd17;
    localparam logic [4:0] KIND_END   = 5'd18;
    localparam logic [4:0] KIND_ERROR = 5'd19;

    localparam logic [1:0] CAUSE_NONE    = 2'd0;
    localparam logic [1:0] CAUSE_CHAR    = 2'd1;
    localparam logic [1:0] CAUSE_COMMENT = 2'd2;
    localparam logic [1:0] CAUSE_LONG    = 2'd3;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;

    localparam logic [5:0] KW_ALL = 6'h3F;

    typedef enum logic [6:0] {
        M_IDLE   = 7'b0000001,
        M_IDENT  = 7'b0000010,
        M_INT    = 7'b0000100,
        M_SLASH  = 7'b0001000,
        M_LINEC  = 7'b0010000,
        M_BLOCKC = 7'b0100000,
        M_ERROR  = 7'b1000000
    } stl_mode_t;

    typedef enum logic [1:0] {
        PC_NONE  = 2'd0,
        PC_SLASH = 2'd1,
        PC_STAR  = 2'd2
    } stl_prev_t;

    typedef struct packed {
        logic [4:0]        kind;
        logic [1:0]        cause;
        logic [LINE_W-1:0] line;
        logic [OFF_W-1:0]  offset;
        logic [LEN_W-1:0]  length;
        logic              last;
    } stl_token_t;

    typedef struct packed {
        logic [1:0] cnt;
        stl_token_t r0;
        stl_token_t r1;
    } stl_push_t;

    function automatic logic [2:0] kw_len(input logic [2:0] k);
        logic [2:0] n;
        case (k)
            3'd0:    n = 3'd4;
            3'd1:    n = 3'd3;
            3'd2:    n = 3'd2;
            3'd3:    n = 3'd4;
            3'd4:    n = 3'd4;
            3'd5:    n = 3'd6;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // Byte idx of keyword k; index 0 is the first letter.
    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] idx);
        logic [5:0][7:0] w;
        logic [7:0]      c;
        case (k)
            3'd0:    w = {8'h00, 8'h00, "t", "i", "x", "e"};
            3'd1:    w = {8'h00, 8'h00, 8'h00, "t", "e", "l"};
            3'd2:    w = {8'h00, 8'h00, 8'h00, 8'h00, "f", "i"};
            3'd3:    w = {8'h00, 8'h00, "f", "i", "l", "e"};
            3'd4:    w = {8'h00, 8'h00, "e", "s", "l", "e"};
            3'd5:    w = {"n", "r", "u", "t", "e", "r"};
            default: w = '0;
        endcase
        case (idx)
            3'd0:    c = w[0];
            3'd1:    c = w[1];
            3'd2:    c = w[2];
            3'd3:    c = w[3];
            3'd4:    c = w[4];
            3'd5:    c = w[5];
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic logic [4:0] sym_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            8'h28:   k = KIND_LPAR;
            8'h29:   k = KIND_RPAR;
            8'h7B:   k = KIND_LBRC;
            8'h7D:   k = KIND_RBRC;
            8'h3D:   k = KIND_EQ;
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2A:   k = KIND_STAR;
            8'h3B:   k = KIND_SEMI;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

[rtl/stl_if.sv]
// Valid/ready channel interfaces for source bytes and tokens.
`default_nettype none

interface stl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_text;

    modport source (output valid, output ch, output end_of_text, input ready);
    modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

interface stl_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [1:0]  error_cause;
    logic [19:0] line_number;
    logic [23:0] start_offset;
    logic [6:0]  token_length;
    logic        last;

    modport source (output valid, output token_kind, output error_cause, output line_number,
                    output start_offset, output token_length, output last, input ready);
    modport sink   (input valid, input token_kind, input error_cause, input line_number,
                    input start_offset, input token_length, input last, output ready);
endinterface

`default_nettype wire

[rtl/stl_core.sv]
// Lexer state registers and the per-byte next-state and token logic.
`default_nettype none

module stl_core
    import stl_pkg::*;
#(
    parameter int MAX_TOKEN_LEN     = 64,
    parameter int MAX_COMMENT_DEPTH = 255,
    parameter int OFFSET_BITS       = 24
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step_en,
    input  wire logic [7:0] ch,
    input  wire logic       end_of_text,
    output stl_push_t       push
);

    localparam int LEN_BITS   = $clog2(MAX_TOKEN_LEN + 1);
    localparam int DEPTH_BITS = $clog2(MAX_COMMENT_DEPTH + 1);
    localparam logic [OFFSET_BITS-1:0] POS_MAX   = {OFFSET_BITS{1'b1}};
    localparam logic [LEN_BITS-1:0]    LEN_LIMIT = LEN_BITS'(MAX_TOKEN_LEN);
    localparam logic [DEPTH_BITS-1:0]  DEPTH_MAX = DEPTH_BITS'(MAX_COMMENT_DEPTH);

    stl_mode_t              mode_reg,  mode_next;
    logic [5:0]             mask_reg,  mask_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [LEN_BITS-1:0]    len_reg,   len_next;
    logic [OFFSET_BITS-1:0] pos_reg,   pos_next;
    logic [LINE_W-1:0]      line_reg,  line_next;
    logic [DEPTH_BITS-1:0]  depth_reg, depth_next;
    stl_prev_t              prev_reg,  prev_next;

    function automatic logic [5:0] mask_upd(input logic [5:0] m, input logic [LEN_BITS-1:0] n,
                                            input logic [7:0] c);
        logic [5:0] r;
        r = m;
        for (int k = 0; k < 6; k++) begin
            if (!(n < LEN_BITS'(kw_len(3'(k))) && kw_char(3'(k), n[2:0]) == c)) begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [4:0] word_kind(input logic [5:0] m, input logic [LEN_BITS-1:0] n);
        logic [4:0] kind;
        kind = KIND_IDENT;
        for (int k = 0; k < 6; k++) begin
            if (m[k] && LEN_BITS'(kw_len(3'(k))) == n) begin
                kind = 5'(k);
            end
        end
        return kind;
    endfunction

    function automatic stl_token_t mk_tok(input logic [4:0] kind, input logic [1:0] cause,
                                          input logic [LINE_W-1:0] line,
                                          input logic [OFFSET_BITS-1:0] off,
                                          input logic [LEN_BITS-1:0] len);
        logic [31:0] off_w;
        stl_token_t  t;
        off_w    = 32'(off);
        t.kind   = kind;
        t.cause  = cause;
        t.line   = line;
        t.offset = off_w[OFF_W-1:0];
        t.length = LEN_W'(len);
        t.last   = 1'b0;
        return t;
    endfunction

    stl_mode_t              i_mode;
    logic [OFFSET_BITS-1:0] i_start;
    logic [LEN_BITS-1:0]    i_len;
    logic [5:0]             i_mask;
    logic                   i_line_inc;
    logic                   i_emit;
    stl_token_t             i_tok;
    logic [4:0]             sk;

    logic       a_emit, b_emit, use_idle, line_inc;
    stl_token_t a_tok, b_tok, r0, r1;

    // Byte as seen by an idle lexer.
    always_comb
    begin
        sk         = sym_kind(ch);
        i_mode     = M_IDLE;
        i_start    = start_reg;
        i_len      = len_reg;
        i_mask     = mask_reg;
        i_line_inc = 1'b0;
        i_emit     = 1'b0;
        i_tok      = mk_tok(sk, CAUSE_NONE, line_reg, pos_reg, LEN_BITS'(1));
        if (is_alpha(ch))
        begin
            i_mode  = M_IDENT;
            i_start = pos_reg;
            i_mask  = mask_upd(KW_ALL, '0, ch);
            i_len   = LEN_BITS'(1);
        end
        else if (is_digit(ch))
        begin
            i_mode  = M_INT;
            i_start = pos_reg;
            i_len   = LEN_BITS'(1);
        end
        else if (ch == CH_SLASH)
        begin
            i_mode  = M_SLASH;
            i_start = pos_reg;
        end
        else if (ch == CH_NL)
        begin
            i_line_inc = 1'b1;
        end
        else if (is_space(ch))
        begin
            i_emit = 1'b0;
        end
        else if (sk != KIND_NONE)
        begin
            i_emit = 1'b1;
        end
        else
        begin
            i_emit = 1'b1;
            i_tok  = mk_tok(KIND_ERROR, CAUSE_CHAR, line_reg, pos_reg, '0);
            i_mode = M_ERROR;
        end
    end

    // Mode step: token A closes what was pending, token B comes from the byte itself.
    always_comb
    begin
        mode_next  = mode_reg;
        mask_next  = mask_reg;
        start_next = start_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        line_next  = line_reg;
        depth_next = depth_reg;
        prev_next  = prev_reg;
        a_emit     = 1'b0;
        a_tok      = mk_tok(word_kind(mask_reg, len_reg), CAUSE_NONE, line_reg, start_reg,
                            len_reg);
        b_emit     = 1'b0;
        b_tok      = i_tok;
        use_idle   = 1'b0;
        line_inc   = 1'b0;

        if (end_of_text)
        begin
            case (mode_reg)
                M_IDENT:
                begin
                    a_emit = 1'b1;
                end
                M_INT:
                begin
                    a_emit = 1'b1;
                    a_tok  = mk_tok(KIND_INT, CAUSE_NONE, line_reg, start_reg, len_reg);
                end
                M_SLASH:
                begin
                    a_emit = 1'b1;
                    a_tok  = mk_tok(KIND_SLASH, CAUSE_NONE, line_reg, start_reg, LEN_BITS'(1));
                end
                M_BLOCKC:
                begin
                    a_emit = 1'b1;
                    a_tok  = mk_tok(KIND_ERROR, CAUSE_COMMENT, line_reg, pos_reg, '0);
                end
                default:
                begin
                    a_emit = 1'b0;
                end
            endcase
            b_emit     = 1'b1;
            b_tok      = mk_tok(KIND_END, CAUSE_NONE, line_reg, pos_reg, '0);
            mode_next  = M_IDLE;
            mask_next  = KW_ALL;
            start_next = '0;
            len_next   = '0;
            pos_next   = '0;
            line_next  = LINE_W'(1);
            depth_next = '0;
            prev_next  = PC_NONE;
        end
        else
        begin
            case (mode_reg)
                M_IDENT, M_INT:
                begin
                    if (is_digit(ch) || (mode_reg == M_IDENT && is_alpha(ch)))
                    begin
                        if (len_reg >= LEN_LIMIT)
                        begin
                            a_emit    = 1'b1;
                            a_tok     = mk_tok(KIND_ERROR, CAUSE_LONG, line_reg, start_reg, '0);
                            mode_next = M_ERROR;
                        end
                        else
                        begin
                            if (mode_reg == M_IDENT)
                            begin
                                mask_next = mask_upd(mask_reg, len_reg, ch);
                            end
                            len_next = len_reg + LEN_BITS'(1);
                        end
                    end
                    else
                    begin
                        a_emit = 1'b1;
                        if (mode_reg == M_INT)
                        begin
                            a_tok = mk_tok(KIND_INT, CAUSE_NONE, line_reg, start_reg, len_reg);
                        end
                        use_idle = 1'b1;
                    end
                end
                M_SLASH:
                begin
                    if (ch == CH_SLASH)
                    begin
                        mode_next = M_LINEC;
                    end
                    else if (ch == CH_STAR)
                    begin
                        mode_next  = M_BLOCKC;
                        depth_next = DEPTH_BITS'(1);
                        prev_next  = PC_NONE;
                    end
                    else
                    begin
                        a_emit   = 1'b1;
                        a_tok    = mk_tok(KIND_SLASH, CAUSE_NONE, line_reg, start_reg,
                                          LEN_BITS'(1));
                        use_idle = 1'b1;
                    end
                end
                M_LINEC:
                begin
                    if (ch == CH_NL)
                    begin
                        line_inc  = 1'b1;
                        mode_next = M_IDLE;
                    end
                end
                M_BLOCKC:
                begin
                    if (prev_reg == PC_SLASH && ch == CH_STAR)
                    begin
                        if (depth_reg < DEPTH_MAX)
                        begin
                            depth_next = depth_reg + DEPTH_BITS'(1);
                        end
                        prev_next = PC_NONE;
                    end
                    else if (prev_reg == PC_STAR && ch == CH_SLASH)
                    begin
                        // Close one level; leave the comment when the last closes.
                        if (depth_reg != '0)
                        begin
                            depth_next = depth_reg - DEPTH_BITS'(1);
                        end
                        prev_next = PC_NONE;
                        if (depth_reg <= DEPTH_BITS'(1))
                        begin
                            mode_next = M_IDLE;
                        end
                    end
                    else
                    begin
                        prev_next = (ch == CH_SLASH) ? PC_SLASH :
                                    (ch == CH_STAR)  ? PC_STAR  : PC_NONE;
                        line_inc  = (ch == CH_NL);
                    end
                end
                M_ERROR:
                begin
                    mode_next = M_ERROR;
                end
                default:
                begin
                    use_idle = 1'b1;
                end
            endcase

            if (use_idle)
            begin
                mode_next  = i_mode;
                start_next = i_start;
                len_next   = i_len;
                mask_next  = i_mask;
                b_emit     = i_emit;
                line_inc   = i_line_inc;
            end

            if (line_inc && line_reg != LINE_MAX)
            begin
                line_next = line_reg + LINE_W'(1);
            end
            if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + OFFSET_BITS'(1);
            end
        end

        r0      = a_emit ? a_tok : b_tok;
        r0.last = !(a_emit && b_emit);
        r1      = b_tok;
        r1.last = 1'b1;
        push.r0  = r0;
        push.r1  = r1;
        push.cnt = step_en ? (2'(a_emit) + 2'(b_emit)) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            mask_reg  <= KW_ALL;
            start_reg <= '0;
            len_reg   <= '0;
            pos_reg   <= '0;
            line_reg  <= LINE_W'(1);
            depth_reg <= '0;
            prev_reg  <= PC_NONE;
        end
        else if (step_en)
        begin
            mode_reg  <= mode_next;
            mask_reg  <= mask_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            line_reg  <= line_next;
            depth_reg <= depth_next;
            prev_reg  <= prev_next;
        end
    end

endmodule

`default_nettype wire

[rtl/stl_fifo.sv]
// Four-entry token queue that takes up to two tokens a cycle and sends one.
`default_nettype none

module stl_fifo
    import stl_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire stl_push_t push,
    output logic           space_ok,
    stl_out_if.source      tokens
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    stl_token_t        mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic              pop;
    stl_token_t        head;

    assign pop      = tokens.valid && tokens.ready;
    assign space_ok = count_reg <= CNT_W'(DEPTH - 2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.cnt) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2)
        begin
            mem[wr_ptr_reg + PTR_W'(1)] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head                = mem[rd_ptr_reg];
    assign tokens.valid        = count_reg != '0;
    assign tokens.token_kind   = head.kind;
    assign tokens.error_cause  = head.cause;
    assign tokens.line_number  = head.line;
    assign tokens.start_offset = head.offset;
    assign tokens.token_length = head.length;
    assign tokens.last         = head.last;

endmodule

`default_nettype wire

[rtl/source_text_lexer_top.sv]
// Source text lexer: byte stream in, token stream out.
//
// Usage: feed one ASCII byte per item on "text" (ch), or an item with
// end_of_text set to close the source. Tokens leave on "tokens", one per
// item, with kind, error cause, start line, start offset and length; "last"
// marks the final token caused by one input item (an item causes zero, one
// or two tokens). An end-of-text item flushes any pending word, number or
// slash, reports an open block comment, sends the end token and restarts
// line and offset counting.
// Throughput: one byte per cycle while the queue has room. The byte logic
// in stl_core is a single registered step, so a token caused by a byte
// accepted at one edge is on the output after that edge.
// The four-entry token queue (stl_fifo) parts the two sides; text.ready is
// high while it has two free entries, so bytes keep flowing while a token
// waits. A byte causes a second token only when the byte before it caused
// none, so with the receiver always ready the queue never fills and a byte
// is taken in every cycle.
// Receiver stall: tokens hold in the queue; once under two entries are free,
// text.ready drops and no byte is lost. Reset: lexer idle, line 1, offset 0,
// queue empty; no clearing pass, the first item is taken right after reset.
`default_nettype none

module source_text_lexer_top
    import stl_pkg::*;
#(
    parameter int MAX_TOKEN_LEN     = 64,
    parameter int MAX_COMMENT_DEPTH = 255,
    parameter int OFFSET_BITS       = 24
) (
    input  wire logic clk,
    input  wire logic rst_n,
    stl_in_if.sink    text,
    stl_out_if.source tokens
);

    logic      space_ok;
    logic      accept;
    stl_push_t push;

    // Take a byte only while the queue can hold both tokens it may cause.
    assign text.ready = space_ok;
    assign accept     = text.valid && space_ok;

    stl_core #(
        .MAX_TOKEN_LEN     (MAX_TOKEN_LEN),
        .MAX_COMMENT_DEPTH (MAX_COMMENT_DEPTH),
        .OFFSET_BITS       (OFFSET_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (accept),
        .ch          (text.ch),
        .end_of_text (text.end_of_text),
        .push        (push)
    );

    stl_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .space_ok (space_ok),
        .tokens   (tokens)
    );

endmodule

`default_nettype wire

[tb/tb_source_text_lexer_top.sv]
// Self-checking testbench for the source text lexer: byte stream in, predicted tokens checked.
`timescale 1ns / 100ps

module tb_source_text_lexer_top
    import stl_pkg::*;
();

    // Block configuration as built; the predictor follows the same limits.
    localparam int MAX_TOKEN_LEN     = 64;
    localparam int MAX_COMMENT_DEPTH = 255;
    localparam logic [OFF_W-1:0] POS_MAX = {OFF_W{1'b1}};

    // Run length and pressure settings.
    localparam int RANDOM_BYTES  = 760;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLDOFF_LEN   = 200;
    localparam int HOLDOFF_FIRST = 300;
    localparam int HOLDOFF_STEP  = 400;
    localparam int HOLDOFF_MAX   = 2;
    localparam int TAIL_CYCLES   = 8;
    localparam int REPORT_CAP    = 40;

    // Receiver stall patterns.
    localparam int STALL_NONE  = 0;
    localparam int STALL_LIGHT = 1;
    localparam int STALL_HEAVY = 2;

    // One entry of the sender's queue: a byte, an end-of-text mark, or a
    // drain marker that holds the sender until every expected token is in.
    typedef struct {
        logic [7:0] ch;
        logic       eot;
        logic       drain;
    } src_item_t;

    logic clk;
    logic rst_n;

    stl_in_if  text_bus ();
    stl_out_if token_bus ();

    source_text_lexer_top #(
        .MAX_TOKEN_LEN     (MAX_TOKEN_LEN),
        .MAX_COMMENT_DEPTH (MAX_COMMENT_DEPTH),
        .OFFSET_BITS       (OFF_W)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_bus),
        .tokens (token_bus)
    );

    // ------------------------------------------------------------------
    // Clock: 2 ns period.
    // ------------------------------------------------------------------
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Lexer predictor state: a private copy of everything the block keeps.
    // ------------------------------------------------------------------
    stl_mode_t         lx_mode;
    logic [5:0]        kw_live;
    logic [OFF_W-1:0]  tok_start;
    logic [LEN_W-1:0]  tok_len;
    logic [OFF_W-1:0]  byte_pos;
    logic [LINE_W-1:0] line_cnt;
    logic [7:0]        nest_depth;
    stl_prev_t         nest_prev;

    stl_token_t step_tokens[$];      // tokens caused by the item being predicted
    stl_token_t expected_tokens[$];  // tokens predicted but not yet seen
    src_item_t  pending_items[$];    // items waiting to be offered

    // Bookkeeping shared between processes.
    logic in_taken;
    int   items_in;
    int   tokens_seen;
    int   error_tokens;
    int   mismatches;
    int   stim_bytes;
    int   texts_built;
    int   holdoff_left;
    int   holdoffs_done;
    int   cycle_count;

    // Sender and receiver pacing.
    int burst_left;
    int gap_left;
    int stall_kind;
    int stall_phase_left;

    stl_token_t got_tok;
    stl_token_t want_tok;

    // ------------------------------------------------------------------
    // Character classes and keyword spelling.
    // ------------------------------------------------------------------
    function automatic string keyword_text(input int k);
        case (k)
            0:       return "exit";
            1:       return "let";
            2:       return "if";
            3:       return "elif";
            4:       return "else";
            5:       return "return";
            default: return "";
        endcase
    endfunction

    function automatic logic letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic blank(input logic [7:0] c);
        return c == " " || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [4:0] symbol_code(input logic [7:0] c);
        case (c)
            "(":     return KIND_LPAR;
            ")":     return KIND_RPAR;
            "{":     return KIND_LBRC;
            "}":     return KIND_RBRC;
            "=":     return KIND_EQ;
            "+":     return KIND_PLUS;
            "-":     return KIND_MINUS;
            "*":     return KIND_STAR;
            ";":     return KIND_SEMI;
            default: return KIND_NONE;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Predictor steps.
    // ------------------------------------------------------------------
    task automatic lex_reset();
        lx_mode    = M_IDLE;
        kw_live    = KW_ALL;
        tok_start  = '0;
        tok_len    = '0;
        byte_pos   = '0;
        line_cnt   = LINE_W'(1);
        nest_depth = '0;
        nest_prev  = PC_NONE;
    endtask

    // Tokens carry the line current at the moment they are produced.
    task automatic put_token(input logic [4:0] kind, input logic [1:0] cause,
                             input logic [OFF_W-1:0] off, input logic [LEN_W-1:0] len);
        stl_token_t t;
        t.kind   = kind;
        t.cause  = cause;
        t.line   = line_cnt;
        t.offset = off;
        t.length = len;
        t.last   = 1'b0;
        step_tokens.push_back(t);
    endtask

    task automatic bump_line();
        if (line_cnt < LINE_MAX)
            line_cnt++;
    endtask

    // Drop every keyword whose next letter is not c.
    task automatic narrow_keywords(input logic [7:0] c);
        string w;
        for (int k = 0; k < 6; k++)
        begin
            w = keyword_text(k);
            if (kw_live[k] && !(int'(tok_len) < w.len() && w[tok_len] == c))
                kw_live[k] = 1'b0;
        end
    endtask

    task automatic flush_word();
        logic [4:0] kind;
        string      w;
        kind = KIND_IDENT;
        for (int k = 0; k < 6; k++)
        begin
            w = keyword_text(k);
            if (kw_live[k] && w.len() == int'(tok_len))
                kind = 5'(k);
        end
        put_token(kind, CAUSE_NONE, tok_start, tok_len);
    endtask

    task automatic from_idle(input logic [7:0] c);
        logic [4:0] sym;
        sym = symbol_code(c);
        lx_mode = M_IDLE;
        if (letter(c))
        begin
            lx_mode   = M_IDENT;
            tok_start = byte_pos;
            tok_len   = '0;
            kw_live   = KW_ALL;
            narrow_keywords(c);
            tok_len   = LEN_W'(1);
        end
        else if (digit(c))
        begin
            lx_mode   = M_INT;
            tok_start = byte_pos;
            tok_len   = LEN_W'(1);
        end
        else if (c == CH_SLASH)
        begin
            lx_mode   = M_SLASH;
            tok_start = byte_pos;
        end
        else if (c == CH_NL)
            bump_line();
        else if (!blank(c))
        begin
            if (sym != KIND_NONE)
                put_token(sym, CAUSE_NONE, byte_pos, LEN_W'(1));
            else
            begin
                put_token(KIND_ERROR, CAUSE_CHAR, byte_pos, '0);
                lx_mode = M_ERROR;
            end
        end
    endtask

    task automatic extend_token(input logic [7:0] c);
        if (tok_len >= MAX_TOKEN_LEN)
        begin
            put_token(KIND_ERROR, CAUSE_LONG, tok_start, '0);
            lx_mode = M_ERROR;
        end
        else
        begin
            if (lx_mode == M_IDENT)
                narrow_keywords(c);
            tok_len++;
        end
    endtask

    task automatic comment_byte(input logic [7:0] c);
        if (nest_prev == PC_SLASH && c == CH_STAR)
        begin
            if (nest_depth < MAX_COMMENT_DEPTH)
                nest_depth++;
            nest_prev = PC_NONE;
        end
        else if (nest_prev == PC_STAR && c == CH_SLASH)
        begin
            if (nest_depth > 0)
                nest_depth--;
            nest_prev = PC_NONE;
            if (nest_depth == 0)
                lx_mode = M_IDLE;
        end
        else
        begin
            nest_prev = (c == CH_SLASH) ? PC_SLASH : (c == CH_STAR) ? PC_STAR : PC_NONE;
            if (c == CH_NL)
                bump_line();
        end
    endtask

    // Work out the tokens one accepted item causes and queue them.
    task automatic predict_item(input logic [7:0] c, input logic eot);
        stl_token_t t;
        step_tokens.delete();
        if (eot)
        begin
            case (lx_mode)
                M_IDENT:  flush_word();
                M_INT:    put_token(KIND_INT, CAUSE_NONE, tok_start, tok_len);
                M_SLASH:  put_token(KIND_SLASH, CAUSE_NONE, tok_start, LEN_W'(1));
                M_BLOCKC: put_token(KIND_ERROR, CAUSE_COMMENT, byte_pos, '0);
                default:  ;
            endcase
            put_token(KIND_END, CAUSE_NONE, byte_pos, '0);
            lex_reset();
        end
        else
        begin
            case (lx_mode)
                M_IDENT:
                begin
                    if (letter(c) || digit(c))
                        extend_token(c);
                    else
                    begin
                        flush_word();
                        from_idle(c);
                    end
                end
                M_INT:
                begin
                    if (digit(c))
                        extend_token(c);
                    else
                    begin
                        put_token(KIND_INT, CAUSE_NONE, tok_start, tok_len);
                        from_idle(c);
                    end
                end
                M_SLASH:
                begin
                    if (c == CH_SLASH)
                        lx_mode = M_LINEC;
                    else if (c == CH_STAR)
                    begin
                        lx_mode    = M_BLOCKC;
                        nest_depth = 8'd1;
                        nest_prev  = PC_NONE;
                    end
                    else
                    begin
                        put_token(KIND_SLASH, CAUSE_NONE, tok_start, LEN_W'(1));
                        from_idle(c);
                    end
                end
                M_LINEC:
                begin
                    if (c == CH_NL)
                    begin
                        bump_line();
                        lx_mode = M_IDLE;
                    end
                end
                M_BLOCKC: comment_byte(c);
                M_ERROR:  ;
                default:  from_idle(c);
            endcase
            if (byte_pos < POS_MAX)
                byte_pos++;
        end
        if (step_tokens.size() > 0)
        begin
            t = step_tokens.pop_back();
            t.last = 1'b1;
            step_tokens.push_back(t);
        end
        foreach (step_tokens[i])
            expected_tokens.push_back(step_tokens[i]);
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_CAP)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders: append items to the sender's queue.
    // ------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] c);
        src_item_t it;
        it.ch    = c;
        it.eot   = 1'b0;
        it.drain = 1'b0;
        pending_items.push_back(it);
        stim_bytes++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    // ch is don't-care on an end item; give it random content.
    task automatic add_end();
        src_item_t it;
        it.ch    = 8'($urandom_range(0, 255));
        it.eot   = 1'b1;
        it.drain = 1'b0;
        pending_items.push_back(it);
        texts_built++;
    endtask

    task automatic add_drain();
        src_item_t it;
        it.ch    = '0;
        it.eot   = 1'b0;
        it.drain = 1'b1;
        pending_items.push_back(it);
    endtask

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    task automatic add_space();
        case ($urandom_range(0, 5))
            0:       add_byte(8'h09);
            1:       add_byte(CH_NL);
            2:       add_byte(8'h0B);
            3:       add_byte(8'h0C);
            4:       add_byte(8'h0D);
            default: add_byte(" ");
        endcase
    endtask

    task automatic add_word(input int len);
        add_byte(rand_letter());
        for (int i = 1; i < len; i++)
            add_byte(($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter());
    endtask

    task automatic add_number(input int len);
        for (int i = 0; i < len; i++)
            add_byte(rand_digit());
    endtask

    // Exact keywords, prefixes of them, and keywords with a tail.
    task automatic add_keyword_like();
        string w;
        int    cut;
        w = keyword_text($urandom_range(0, 5));
        case ($urandom_range(0, 3))
            0:
            begin
                cut = $urandom_range(1, w.len() - 1);
                add_text(w.substr(0, cut - 1));
            end
            1:
            begin
                add_text(w);
                add_byte(($urandom_range(0, 1) == 0) ? rand_letter() : rand_digit());
            end
            default: add_text(w);
        endcase
    endtask

    task automatic add_line_comment();
        add_text("//");
        repeat ($urandom_range(0, 6))
        begin
            case ($urandom_range(0, 4))
                0:       add_byte(CH_SLASH);
                1:       add_byte(CH_STAR);
                2:       add_byte(" ");
                default: add_byte(rand_letter());
            endcase
        end
        if ($urandom_range(0, 9) != 0)
            add_byte(CH_NL);
    endtask

    // Balanced nested comment; lone stars and slashes are kept off pairs.
    task automatic add_block_comment(input int depth);
        add_text("/*");
        repeat ($urandom_range(0, 4))
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    add_byte(CH_STAR);
                    add_byte(rand_letter());
                end
                1:
                begin
                    add_byte(CH_SLASH);
                    add_byte(rand_digit());
                end
                2:       add_byte(CH_NL);
                3:
                begin
                    if (depth > 1)
                        add_block_comment(depth - 1);
                    else
                        add_byte(" ");
                end
                default: add_byte(rand_letter());
            endcase
        end
        add_text("*/");
    endtask

    task automatic add_symbol();
        string syms;
        syms = "(){}=+-*/;";
        add_byte(syms[$urandom_range(0, 9)]);
    endtask

    // One random source text: mostly well-formed tokens, a little noise.
    task automatic gen_text();
        int r;
        repeat ($urandom_range(3, 16))
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
                add_text(keyword_text($urandom_range(0, 5)));
            else if (r < 23)
                add_keyword_like();
            else if (r < 38)
                add_word(($urandom_range(0, 29) == 0) ? $urandom_range(62, 66)
                                                      : $urandom_range(1, 8));
            else if (r < 48)
                add_number(($urandom_range(0, 29) == 0) ? $urandom_range(62, 66)
                                                        : $urandom_range(1, 6));
            else if (r < 68)
                add_symbol();
            else if (r < 76)
                add_space();
            else if (r < 82)
                add_line_comment();
            else if (r < 89)
                add_block_comment($urandom_range(1, 3));
            else if (r < 91)
                add_byte(8'($urandom_range(0, 255)));
            else
                add_byte(CH_NL);
            if ($urandom_range(0, 1) == 0)
                add_space();
        end
        r = $urandom_range(0, 99);
        if (r < 6)
        begin
            add_text("/*");
            add_word($urandom_range(1, 3));
        end
        else if (r < 10)
            add_byte(CH_SLASH);
        add_end();
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge. The predictor runs
    // on every accepted item; every accepted token is checked against the
    // oldest expectation. A token from an item accepted at this edge cannot
    // appear until the next one, so the order inside this block is safe.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= text_bus.valid && text_bus.ready;
            if (text_bus.valid && text_bus.ready)
            begin
                predict_item(text_bus.ch, text_bus.end_of_text);
                items_in++;
            end
            if (token_bus.valid && token_bus.ready)
            begin
                got_tok.kind   = token_bus.token_kind;
                got_tok.cause  = token_bus.error_cause;
                got_tok.line   = token_bus.line_number;
                got_tok.offset = token_bus.start_offset;
                got_tok.length = token_bus.token_length;
                got_tok.last   = token_bus.last;
                if (got_tok.kind == KIND_ERROR)
                    error_tokens++;
                if (expected_tokens.size() == 0)
                    report_mismatch($sformatf("unexpected token kind %0d line %0d offset %0d",
                                              got_tok.kind, got_tok.line, got_tok.offset));
                else
                begin
                    want_tok = expected_tokens.pop_front();
                    if (got_tok !== want_tok)
                        report_mismatch($sformatf(
                            "#%0d got %0d/%0d/%0d/%0d/%0d/%0b want %0d/%0d/%0d/%0d/%0d/%0b",
                            tokens_seen, got_tok.kind, got_tok.cause, got_tok.line,
                            got_tok.offset, got_tok.length, got_tok.last, want_tok.kind,
                            want_tok.cause, want_tok.line, want_tok.offset, want_tok.length,
                            want_tok.last));
                end
                tokens_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: change inputs on the falling edge. An offered item holds until
    // it is taken. Between items the sender runs in bursts with random gaps;
    // gaps are dropped while the receiver is in a long hold-off so the block
    // keeps being pushed. A drain marker holds the sender until every
    // expected token has arrived.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
                void'(pending_items.pop_front());
            if (!(text_bus.valid && !in_taken))
            begin
                if (pending_items.size() == 0)
                    text_bus.valid <= 1'b0;
                else if (pending_items[0].drain)
                begin
                    text_bus.valid <= 1'b0;
                    if (expected_tokens.size() == 0)
                        void'(pending_items.pop_front());
                end
                else if (gap_left > 0 && holdoff_left == 0)
                begin
                    gap_left--;
                    text_bus.valid <= 1'b0;
                end
                else
                begin
                    text_bus.valid       <= 1'b1;
                    text_bus.ch          <= pending_items[0].ch;
                    text_bus.end_of_text <= pending_items[0].eot;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready changes on the falling edge. It switches between
    // stretches of no stall, light and heavy random stalls; twice it holds
    // off for a long stretch so the token queue fills and input stalls.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (holdoff_left > 0)
            begin
                token_bus.ready <= 1'b0;
                holdoff_left    <= holdoff_left - 1;
            end
            else if (holdoffs_done < HOLDOFF_MAX &&
                     items_in >= HOLDOFF_FIRST + HOLDOFF_STEP * holdoffs_done)
            begin
                token_bus.ready <= 1'b0;
                holdoff_left    <= HOLDOFF_LEN;
                holdoffs_done++;
            end
            else
            begin
                if (stall_phase_left == 0)
                begin
                    stall_kind       = $urandom_range(STALL_NONE, STALL_HEAVY);
                    stall_phase_left = $urandom_range(10, 150);
                end
                stall_phase_left--;
                case (stall_kind)
                    STALL_NONE:  token_bus.ready <= 1'b1;
                    STALL_LIGHT: token_bus.ready <= ($urandom_range(0, 3) != 0);
                    default:     token_bus.ready <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if it goes far beyond any correct run.
    // ------------------------------------------------------------------
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TIMEOUT after %0d cycles: %0d items pending, %0d tokens expected",
                 cycle_count, pending_items.size(), expected_tokens.size());
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence: build the stimulus, reset once, wait for completion.
    // ------------------------------------------------------------------
    initial
    begin
        int base;
        clk                  = 1'b0;
        rst_n                = 1'b0;
        text_bus.valid       = 1'b0;
        text_bus.ch          = '0;
        text_bus.end_of_text = 1'b0;
        token_bus.ready      = 1'b0;
        in_taken             = 1'b0;
        items_in             = 0;
        tokens_seen          = 0;
        error_tokens         = 0;
        mismatches           = 0;
        stim_bytes           = 0;
        texts_built          = 0;
        holdoff_left         = 0;
        holdoffs_done        = 0;
        burst_left           = 0;
        gap_left             = 0;
        stall_kind           = STALL_NONE;
        stall_phase_left     = 0;
        lex_reset();

        // Directed: keyword ended by a symbol, number ended by a slash that
        // opens a line comment, nested block comment with a shared slash and
        // newlines inside, word ended by a lone slash, lone slash ended by a
        // symbol (two tokens from one byte), invalid zero byte, an ignored
        // byte after the error, then end of text.
        add_text("if+7//c");
        add_byte(CH_NL);
        add_text("/*/**/");
        add_byte(CH_NL);
        add_text("*/x/;");
        add_byte(8'h00);
        add_byte(8'hFF);
        add_end();
        // Unterminated block comment, then a lone slash flushed by end of text.
        add_text("/*");
        add_end();
        add_byte(CH_SLASH);
        add_end();
        add_drain();

        // Longest integer the block accepts, then a word that runs over.
        add_number(MAX_TOKEN_LEN);
        add_byte(" ");
        add_word(MAX_TOKEN_LEN + 1);
        add_end();

        base = stim_bytes;
        while (stim_bytes - base < RANDOM_BYTES)
        begin
            gen_text();
            if (texts_built % 6 == 0)
                add_drain();
        end
        add_drain();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || expected_tokens.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_tokens.size() != 0)
            report_mismatch($sformatf("%0d tokens never arrived", expected_tokens.size()));

        $display("Lexed %0d items over %0d texts; %0d tokens checked, %0d of them errors.",
                 items_in, texts_built, tokens_seen, error_tokens);
        $display("Receiver long hold-offs: %0d; mismatches: %0d; cycles: %0d.",
                 holdoffs_done, mismatches, cycle_count);
        if (mismatches == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
